@@ rtl/loop_branch_control_stack_top_assert.svh @@
// Assertion macros used by the checker file of the control stack.
// Each macro samples on the rising edge of clk and is switched off while rst_n is low.
`ifndef LOOP_BRANCH_CONTROL_STACK_TOP_ASSERT_SVH
`define LOOP_BRANCH_CONTROL_STACK_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lbcs_pkg.sv @@
package lbcs_pkg;

  // Stack geometry and field widths.
  localparam int STACK_DEPTH = 16;
  localparam int COUNT_W     = 16;
  localparam int LIMIT_W     = 16;
  localparam int KIND_W      = 2;
  localparam int DEPTH_W     = 5;
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W       = (COUNT_W > LIMIT_W) ? COUNT_W : LIMIT_W;

  // Stream word widths.
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 16;

  localparam logic [LIMIT_W-1:0] DFLT_LIMIT_RESET = LIMIT_W'(1000);
  localparam logic [KIND_W-1:0]  KIND_IF          = KIND_W'(0);

  typedef enum logic [1:0] {
    REQ_ENTER    = 2'd0,
    REQ_CONTINUE = 2'd1,
    REQ_EXIT     = 2'd2,
    REQ_BREAK    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    req_t                req;
    logic [KIND_W-1:0]   kind;
    logic                cond;
    logic [LIMIT_W-1:0]  limit;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic                again;
    logic                exec;
    logic [DEPTH_W-1:0]  depth;
  } result_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic                cond;
    logic [COUNT_W-1:0]  count;
    logic [LIMIT_W-1:0]  limit;
  } frame_t;

endpackage

@@ rtl/lbcs_stack.sv @@
module lbcs_stack (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            go,
  input  lbcs_pkg::item_t                 item,
  input  logic [lbcs_pkg::LIMIT_W-1:0]    dflt_limit,
  output lbcs_pkg::result_t               res
);
  import lbcs_pkg::*;

  localparam int NEXT_IDX = (STACK_DEPTH > 1) ? 1 : 0;

  // The top frame lives in entry 0; push shifts down, pop shifts up.
  frame_t           stk_r   [STACK_DEPTH];
  frame_t           stk_nxt [STACK_DEPTH];
  logic [PTR_W-1:0] top_r, top_nxt;
  logic             brk_r, brk_nxt;

  frame_t             top_frm, new_frm, upd_frm;
  logic [COUNT_W-1:0] cnt_inc;
  logic               again_c, exec_cond, push, pop, upd;

  // Work out the request against the top frame and the pointer.
  always_comb begin
    top_frm = stk_r[0];
    cnt_inc = (&top_frm.count) ? top_frm.count : top_frm.count + COUNT_W'(1);
    upd_frm       = top_frm;
    upd_frm.count = cnt_inc;
    again_c       = 1'b0;
    if (CMP_W'(cnt_inc) < CMP_W'(top_frm.limit)) begin
      upd_frm.cond = item.cond;
      again_c      = item.cond;
    end

    new_frm.kind  = item.kind;
    new_frm.cond  = item.cond;
    new_frm.count = '0;
    new_frm.limit = (item.limit != '0) ? item.limit : dflt_limit;

    push       = 1'b0;
    pop        = 1'b0;
    upd        = 1'b0;
    top_nxt    = top_r;
    brk_nxt    = brk_r;
    exec_cond  = top_frm.cond;
    res.status = ST_OK;
    res.again  = 1'b0;

    unique case (item.req)
      REQ_ENTER: begin
        if (top_r == PTR_W'(STACK_DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          push      = 1'b1;
          top_nxt   = top_r + PTR_W'(1);
          exec_cond = item.cond;
        end
      end
      REQ_CONTINUE: begin
        if (top_r == '0) begin
          res.status = ST_EMPTY;
        end else if (top_frm.kind != KIND_IF) begin
          upd       = 1'b1;
          res.again = again_c;
          exec_cond = upd_frm.cond;
        end
      end
      REQ_EXIT: begin
        if (top_r == '0) begin
          res.status = ST_EMPTY;
        end else begin
          pop       = 1'b1;
          top_nxt   = top_r - PTR_W'(1);
          brk_nxt   = 1'b0;
          exec_cond = stk_r[NEXT_IDX].cond;
        end
      end
      REQ_BREAK: begin
        brk_nxt = 1'b1;
      end
    endcase

    if (brk_nxt) begin
      res.exec = 1'b0;
    end else if (top_nxt == '0) begin
      res.exec = 1'b1;
    end else begin
      res.exec = exec_cond;
    end
    res.depth = DEPTH_W'(top_nxt);
  end

  // Next contents of the frame stack.
  always_comb begin
    stk_nxt = stk_r;
    if (push) begin
      stk_nxt[0] = new_frm;
      for (int k = 1; k < STACK_DEPTH; k++) begin
        stk_nxt[k] = stk_r[k-1];
      end
    end else if (pop) begin
      for (int k = 0; k < STACK_DEPTH - 1; k++) begin
        stk_nxt[k] = stk_r[k+1];
      end
    end else if (upd) begin
      stk_nxt[0] = upd_frm;
    end
  end

  // Pointer and break flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
      brk_r <= 1'b0;
    end else if (go) begin
      top_r <= top_nxt;
      brk_r <= brk_nxt;
    end
  end

  // Frame contents carry no reset; entries at or above the pointer never affect a result.
  always_ff @(posedge clk) begin
    if (go) begin
      stk_r <= stk_nxt;
    end
  end

endmodule

@@ rtl/loop_branch_control_stack_top.sv @@
// Loop and branch control stack: takes one request word per cycle (enter, loop continue,
// exit, break) and returns one result word for each, in order. A request sits in an input
// register while the top frame and stack pointer are updated, and its result is
// registered in the output register when the request advances. The sustained rate is one
// request per cycle while the output is not stalled, as the top frame is updated each time
// a request advances. A stalled output holds the input register and then the input side.
// The default iteration limit is to be written by the user through the cfg port only
// while the block is idle; the block itself does not enforce this.
module loop_branch_control_stack_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // condition [0], iteration_limit [16:1], zero fill above
  input  logic [lbcs_pkg::IN_TDATA_W-1:0]     in_tdata,
  // req_type [1:0], block_kind [3:2]
  input  logic [lbcs_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status [1:0], loop_again [2], should_execute [3], stack_depth [8:4], zero fill above
  output logic [lbcs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lbcs_pkg::LIMIT_W-1:0]        cfg_data
);
  import lbcs_pkg::*;

  logic               in_vld_r, out_vld_r;
  item_t              in_item_r;
  result_t            out_res_r, res;
  logic [LIMIT_W-1:0] dflt_r;
  logic               advance;

  // A request moves on when the result register is free or being emptied.
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_r <= DFLT_LIMIT_RESET;
    end else if (cfg_valid) begin
      dflt_r <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.req   <= req_t'(in_tuser[1:0]);
      in_item_r.kind  <= in_tuser[3:2];
      in_item_r.cond  <= in_tdata[0];
      in_item_r.limit <= in_tdata[LIMIT_W:1];
    end
  end

  lbcs_stack u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (advance),
    .item       (in_item_r),
    .dflt_limit (dflt_r),
    .res        (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'({out_res_r.depth, out_res_r.exec, out_res_r.again,
                                    out_res_r.status});

endmodule

@@ rtl/lbcs_checker.sv @@
`include "loop_branch_control_stack_top_assert.svh"

module lbcs_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [lbcs_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import lbcs_pkg::*;

  logic [1:0]         st;
  logic               again;
  logic [DEPTH_W-1:0] depth;

  assign st    = out_tdata[1:0];
  assign again = out_tdata[2];
  assign depth = out_tdata[DEPTH_W+3:4];

  // A result word waiting on the consumer is held unchanged.
  `LBCS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && out_tdata == $past(out_tdata), "result word changed while stalled")

  // A refused enter leaves the stack at its full depth.
  `LBCS_ASSERT_NOW(a_full_depth, out_tvalid && st == ST_FULL, depth == DEPTH_W'(STACK_DEPTH), "full status with stack not full")

  // An empty report only comes with no open frames.
  `LBCS_ASSERT_NOW(a_empty_depth, out_tvalid && st == ST_EMPTY, depth == '0, "empty status with open frames")

  // A loop answer of one needs an open frame and a successful request.
  `LBCS_ASSERT_NOW(a_again_ok, out_tvalid && again, st == ST_OK && depth != '0, "loop answer without an open frame")

endmodule

bind loop_branch_control_stack_top lbcs_checker u_lbcs_checker (.*);
